// File: hdl/pgp_pkg.sv
// Shared types, constants and helper functions of the pixel ground projection block.
`default_nettype none

package pgp_pkg;

    // Build-time placement of the projection.
    localparam int START_ROW       = 0;
    localparam int CAM_OFFSET_X_MM = 0;

    // Iteration counts of the shared units.
    localparam int CORDIC_STEPS = 17;
    localparam int DIV_STEPS    = 62;
    localparam int ITER_W       = 6;

    // Angle constants in 2^-16 rad and CORDIC start value in Q30.
    localparam logic signed [19:0] ANG_PI      = 20'sd205887;
    localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S24_MIN = 24'sh800000;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CAM_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_CAM_PITCH    = 3'd3;
    localparam logic [2:0] REG_FOCAL_LENGTH = 3'd4;
    localparam logic [2:0] REG_ROBOT_X      = 3'd5;
    localparam logic [2:0] REG_ROBOT_Y      = 3'd6;
    localparam logic [2:0] REG_ROBOT_HEADING = 3'd7;

    // Datapath operations issued by the controller.
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_CINIT_P   = 5'd1;
    localparam logic [4:0] OP_CINIT_H   = 5'd2;
    localparam logic [4:0] OP_CSTEP     = 5'd3;
    localparam logic [4:0] OP_CDONE_P   = 5'd4;
    localparam logic [4:0] OP_CDONE_H   = 5'd5;
    localparam logic [4:0] OP_MUL_F2CP  = 5'd6;
    localparam logic [4:0] OP_MUL_D2SP  = 5'd7;
    localparam logic [4:0] OP_MUL_F2SP  = 5'd8;
    localparam logic [4:0] OP_MUL_D2CP  = 5'd9;
    localparam logic [4:0] OP_MUL_HCLO  = 5'd10;
    localparam logic [4:0] OP_MUL_HCHI  = 5'd11;
    localparam logic [4:0] OP_DIVR_SET  = 5'd12;
    localparam logic [4:0] OP_DIV_STEP  = 5'd13;
    localparam logic [4:0] OP_DIVR_DONE = 5'd14;
    localparam logic [4:0] OP_MUL_RCP   = 5'd15;
    localparam logic [4:0] OP_MUL_HCSP  = 5'd16;
    localparam logic [4:0] OP_RP        = 5'd17;
    localparam logic [4:0] OP_MUL_RPW2  = 5'd18;
    localparam logic [4:0] OP_DIVY_SET  = 5'd19;
    localparam logic [4:0] OP_DIVY_DONE = 5'd20;
    localparam logic [4:0] OP_MUL_XCH   = 5'd21;
    localparam logic [4:0] OP_MUL_YSH   = 5'd22;
    localparam logic [4:0] OP_MUL_XSH   = 5'd23;
    localparam logic [4:0] OP_MUL_YCH   = 5'd24;
    localparam logic [4:0] OP_WY        = 5'd25;
    localparam logic [4:0] OP_EMIT_PT   = 5'd26;
    localparam logic [4:0] OP_EMIT_BOX  = 5'd27;

    typedef struct packed {
        logic [12:0] line_width;
        logic [12:0] line_count;
        logic [11:0] camera_height_mm;
        logic [16:0] cam_tilt;
        logic [15:0] focal_length_px;
        logic [23:0] robot_x_mm;
        logic [23:0] robot_y_mm;
        logic [18:0] robot_heading;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic [4:0]        op;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic mark;
        logic last;
        logic out_full;
    } t_sts;

    // Arctangent of 2^-i in 2^-16 rad.
    function automatic logic signed [19:0] atan_entry(input logic [4:0] idx);
        logic signed [19:0] v;
        begin
            case (idx)
                5'd0:    v = 20'sd51472;
                5'd1:    v = 20'sd30385;
                5'd2:    v = 20'sd16055;
                5'd3:    v = 20'sd8150;
                5'd4:    v = 20'sd4091;
                5'd5:    v = 20'sd2047;
                5'd6:    v = 20'sd1024;
                5'd7:    v = 20'sd512;
                5'd8:    v = 20'sd256;
                5'd9:    v = 20'sd128;
                5'd10:   v = 20'sd64;
                5'd11:   v = 20'sd32;
                5'd12:   v = 20'sd16;
                5'd13:   v = 20'sd8;
                5'd14:   v = 20'sd4;
                5'd15:   v = 20'sd2;
                5'd16:   v = 20'sd1;
                default: v = 20'sd0;
            endcase
            return v;
        end
    endfunction

    // Clamp a wide signed value to the signed 24-bit range.
    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        begin
            if (v > 64'sd8388607) begin
                r = S24_MAX;
            end else if (v < -64'sd8388608) begin
                r = S24_MIN;
            end else begin
                r = v[23:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/pgp_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module pgp_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output pgp_pkg::t_cfg      o_cfg
);

    pgp_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Register writes; reset loads the default camera geometry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width       <= 13'd640;
            r_cfg.line_count       <= 13'd480;
            r_cfg.camera_height_mm <= 12'd500;
            r_cfg.cam_tilt         <= 17'd16384;
            r_cfg.focal_length_px  <= 16'd500;
            r_cfg.robot_x_mm       <= 24'd0;
            r_cfg.robot_y_mm       <= 24'd0;
            r_cfg.robot_heading    <= 19'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                pgp_pkg::REG_FRAME_WIDTH:   r_cfg.line_width       <= pwdata[12:0];
                pgp_pkg::REG_FRAME_HEIGHT:  r_cfg.line_count       <= pwdata[12:0];
                pgp_pkg::REG_CAM_HEIGHT:    r_cfg.camera_height_mm <= pwdata[11:0];
                pgp_pkg::REG_CAM_PITCH:     r_cfg.cam_tilt         <= pwdata[16:0];
                pgp_pkg::REG_FOCAL_LENGTH:  r_cfg.focal_length_px  <= pwdata[15:0];
                pgp_pkg::REG_ROBOT_X:       r_cfg.robot_x_mm       <= pwdata[23:0];
                pgp_pkg::REG_ROBOT_Y:       r_cfg.robot_y_mm       <= pwdata[23:0];
                pgp_pkg::REG_ROBOT_HEADING: r_cfg.robot_heading    <= pwdata[18:0];
                default: ;
            endcase
        end
    end

    // Read-back of the raw register bits.
    always_comb begin
        unique case (reg_idx)
            pgp_pkg::REG_FRAME_WIDTH:   prdata = {19'd0, r_cfg.line_width};
            pgp_pkg::REG_FRAME_HEIGHT:  prdata = {19'd0, r_cfg.line_count};
            pgp_pkg::REG_CAM_HEIGHT:    prdata = {20'd0, r_cfg.camera_height_mm};
            pgp_pkg::REG_CAM_PITCH:     prdata = {15'd0, r_cfg.cam_tilt};
            pgp_pkg::REG_FOCAL_LENGTH:  prdata = {16'd0, r_cfg.focal_length_px};
            pgp_pkg::REG_ROBOT_X:       prdata = {8'd0, r_cfg.robot_x_mm};
            pgp_pkg::REG_ROBOT_Y:       prdata = {8'd0, r_cfg.robot_y_mm};
            pgp_pkg::REG_ROBOT_HEADING: prdata = {13'd0, r_cfg.robot_heading};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/pgp_dp.sv
// Datapath: shared CORDIC, multiplier and divider, bounds tracking and result register.
`default_nettype none

module pgp_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  pgp_pkg::t_cfg      i_cfg,
    input  pgp_pkg::t_cmd      i_cmd,
    input  wire logic [11:0]   i_row,
    input  wire logic [11:0]   i_col,
    input  wire logic          i_flag,
    input  wire logic          i_last,
    input  wire logic          i_out_tready,
    output pgp_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output logic               o_kind,
    output logic      [23:0]   o_first_x,
    output logic      [23:0]   o_first_y,
    output logic      [23:0]   o_second_x,
    output logic      [23:0]   o_second_y,
    output logic               o_bounds_empty,
    output logic               o_last_result
);

    // Latched request.
    logic [11:0] r_row, r_col;
    logic        r_flag, r_last;

    // CORDIC registers and the sine/cosine results.
    logic signed [31:0] r_cx, r_cy, r_sp, r_cp, r_sh, r_ch;
    logic signed [19:0] r_cz;
    logic               r_cneg;

    // Multiplier and accumulation.
    logic signed [63:0] r_prod, r_acc;
    logic signed [49:0] r_num, r_den;
    logic signed [31:0] m_a, m_b;

    // Divider.
    logic [61:0] r_dvd, r_quo;
    logic [50:0] r_rem;
    logic [49:0] r_dvs;
    logic        r_dneg, r_dzero, r_nz;

    // Intermediate and world results.
    logic signed [23:0] r_r, r_x, r_y, r_wx, r_wy;
    logic signed [31:0] r_rp;

    // Frame bounds.
    logic signed [23:0] r_minx, r_miny, r_maxx, r_maxy;
    logic               r_any;

    // Output register.
    logic        r_ovalid, r_okind, r_oempty, r_olast;
    logic [23:0] r_ofx, r_ofy, r_osx, r_osy;

    logic [17:0]        f2;
    logic signed [14:0] d2, w2;
    logic signed [19:0] ang, fold_z;
    logic               fold_neg;
    logic [4:0]         sh_amt;
    logic signed [31:0] dx, dy;
    logic signed [19:0] atn;
    logic signed [63:0] sum_v, div_v, sum_add, sum_sub;
    logic [61:0]        v_mag;
    logic [50:0]        rem_sh;
    logic               q_bit;
    logic signed [23:0] quo_s24;
    logic signed [63:0] rp_full, wx_full, wy_full;

    // Derived pixel and camera terms.
    assign f2 = {1'b0, ((i_cfg.focal_length_px == 16'd0) ? 16'd1 : i_cfg.focal_length_px),
                 1'b0};
    assign d2 = $signed({2'b00, r_row, 1'b0}) - $signed({2'b00, i_cfg.line_count});
    assign w2 = $signed({2'b00, r_col, 1'b0}) - $signed({2'b00, i_cfg.line_width});

    // Status toward the controller.
    assign o_sts.mark = !r_flag && ({1'b0, r_row} >= 13'(pgp_pkg::START_ROW)) &&
                        ({1'b0, r_row} < i_cfg.line_count) &&
                        ({1'b0, r_col} < i_cfg.line_width);
    assign o_sts.last     = r_last;
    assign o_sts.out_full = r_ovalid;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row  <= i_row;
            r_col  <= i_col;
            r_flag <= i_flag;
            r_last <= i_last;
        end
    end

    // Angle folding into the CORDIC range; one fold by pi covers every register value.
    assign ang = (i_cmd.op == pgp_pkg::OP_CINIT_P) ? $signed({3'b000, i_cfg.cam_tilt})
                                                   : 20'(signed'(i_cfg.robot_heading));
    always_comb begin
        fold_z   = ang;
        fold_neg = 1'b0;
        if (ang > pgp_pkg::ANG_HALF_PI) begin
            fold_z   = ang - pgp_pkg::ANG_PI;
            fold_neg = 1'b1;
        end else if (ang < -pgp_pkg::ANG_HALF_PI) begin
            fold_z   = ang + pgp_pkg::ANG_PI;
            fold_neg = 1'b1;
        end
    end

    assign sh_amt = i_cmd.iter[4:0];
    assign dx     = r_cx >>> sh_amt;
    assign dy     = r_cy >>> sh_amt;
    assign atn    = pgp_pkg::atan_entry(sh_amt);

    // CORDIC rotation, one micro-rotation per cycle.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pgp_pkg::OP_CINIT_P, pgp_pkg::OP_CINIT_H: begin
                r_cx   <= pgp_pkg::CORDIC_GAIN;
                r_cy   <= 32'sd0;
                r_cz   <= fold_z;
                r_cneg <= fold_neg;
            end
            pgp_pkg::OP_CSTEP: begin
                if (r_cz >= 20'sd0) begin
                    r_cx <= r_cx - dy;
                    r_cy <= r_cy + dx;
                    r_cz <= r_cz - atn;
                end else begin
                    r_cx <= r_cx + dy;
                    r_cy <= r_cy - dx;
                    r_cz <= r_cz + atn;
                end
            end
            pgp_pkg::OP_CDONE_P: begin
                r_sp <= r_cneg ? -r_cy : r_cy;
                r_cp <= r_cneg ? -r_cx : r_cx;
            end
            pgp_pkg::OP_CDONE_H: begin
                r_sh <= r_cneg ? -r_cy : r_cy;
                r_ch <= r_cneg ? -r_cx : r_cx;
            end
            default: ;
        endcase
    end

    // Multiplier operand selection.
    always_comb begin
        m_a = 32'sd0;
        m_b = 32'sd0;
        case (i_cmd.op)
            pgp_pkg::OP_MUL_F2CP: begin m_a = $signed({14'd0, f2}); m_b = r_cp; end
            pgp_pkg::OP_MUL_D2SP: begin m_a = 32'(d2); m_b = r_sp; end
            pgp_pkg::OP_MUL_F2SP: begin m_a = $signed({14'd0, f2}); m_b = r_sp; end
            pgp_pkg::OP_MUL_D2CP: begin m_a = 32'(d2); m_b = r_cp; end
            pgp_pkg::OP_MUL_HCLO: begin
                m_a = $signed({20'd0, i_cfg.camera_height_mm});
                m_b = $signed({8'd0, r_num[23:0]});
            end
            pgp_pkg::OP_MUL_HCHI: begin
                m_a = $signed({20'd0, i_cfg.camera_height_mm});
                m_b = 32'(signed'(r_num[49:24]));
            end
            pgp_pkg::OP_MUL_RCP:  begin m_a = 32'(r_r); m_b = r_cp; end
            pgp_pkg::OP_MUL_HCSP: begin
                m_a = $signed({20'd0, i_cfg.camera_height_mm});
                m_b = r_sp;
            end
            pgp_pkg::OP_MUL_RPW2: begin m_a = r_rp; m_b = 32'(w2); end
            pgp_pkg::OP_MUL_XCH:  begin m_a = 32'(r_x); m_b = r_ch; end
            pgp_pkg::OP_MUL_YSH:  begin m_a = 32'(r_y); m_b = r_sh; end
            pgp_pkg::OP_MUL_XSH:  begin m_a = 32'(r_x); m_b = r_sh; end
            pgp_pkg::OP_MUL_YCH:  begin m_a = 32'(r_y); m_b = r_ch; end
            default: ;
        endcase
    end

    assign sum_add = r_acc + r_prod;
    assign sum_sub = r_acc - r_prod;
    assign sum_v   = r_acc + (r_prod <<< 24);
    assign div_v   = (i_cmd.op == pgp_pkg::OP_DIVR_SET) ? sum_v : -r_prod;
    assign v_mag   = div_v[63] ? 62'(-div_v) : div_v[61:0];
    assign rp_full = (sum_add + 64'sd536870912) >>> 30;
    assign wx_full = 64'(signed'(i_cfg.robot_x_mm)) + ((sum_sub + 64'sd536870912) >>> 30);
    assign wy_full = 64'(signed'(i_cfg.robot_y_mm)) + ((sum_add + 64'sd536870912) >>> 30);

    // Product register and accumulation steps.
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        case (i_cmd.op)
            pgp_pkg::OP_MUL_D2SP, pgp_pkg::OP_MUL_D2CP, pgp_pkg::OP_MUL_HCHI,
            pgp_pkg::OP_MUL_HCSP, pgp_pkg::OP_MUL_YSH, pgp_pkg::OP_MUL_YCH: r_acc <= r_prod;
            pgp_pkg::OP_MUL_F2SP: r_num  <= sum_sub[49:0];
            pgp_pkg::OP_MUL_HCLO: r_den  <= sum_add[49:0];
            pgp_pkg::OP_RP:       r_rp   <= rp_full[31:0];
            pgp_pkg::OP_MUL_XSH:  r_wx   <= pgp_pkg::sat24(wx_full);
            pgp_pkg::OP_WY:       r_wy   <= pgp_pkg::sat24(wy_full);
            default: ;
        endcase
    end

    // Quotient magnitude with sign, clamped to 24 bits.
    always_comb begin
        if (!r_dneg) begin
            quo_s24 = (r_quo > 62'd8388607) ? pgp_pkg::S24_MAX : r_quo[23:0];
        end else begin
            quo_s24 = (r_quo > 62'd8388608) ? pgp_pkg::S24_MIN : 24'(~r_quo[23:0] + 24'd1);
        end
    end

    assign rem_sh = {r_rem[49:0], r_dvd[61]};
    assign q_bit  = rem_sh >= {1'b0, r_dvs};

    // Restoring divider on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pgp_pkg::OP_DIVR_SET, pgp_pkg::OP_DIVY_SET: begin
                r_dvd  <= v_mag;
                r_rem  <= 51'd0;
                r_quo  <= 62'd0;
                r_nz   <= div_v != 64'sd0;
                if (i_cmd.op == pgp_pkg::OP_DIVR_SET) begin
                    // The quotient is negative when dividend and divisor differ in sign.
                    r_dneg  <= div_v[63] ^ r_den[49];
                    r_dvs   <= r_den[49] ? 50'(-r_den) : r_den;
                    r_dzero <= r_den == 50'sd0;
                end else begin
                    r_dneg  <= div_v[63];
                    r_dvs   <= {32'd0, f2};
                    r_dzero <= 1'b0;
                end
            end
            pgp_pkg::OP_DIV_STEP: begin
                r_dvd <= {r_dvd[60:0], 1'b0};
                r_quo <= {r_quo[60:0], q_bit};
                r_rem <= q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            end
            pgp_pkg::OP_DIVR_DONE: begin
                if (r_dzero) begin
                    r_r <= r_nz ? (r_dneg ? pgp_pkg::S24_MIN : pgp_pkg::S24_MAX) : 24'sd0;
                end else begin
                    r_r <= quo_s24;
                end
            end
            pgp_pkg::OP_MUL_RCP:
                r_x <= pgp_pkg::sat24(64'(r_r) + 64'(pgp_pkg::CAM_OFFSET_X_MM));
            pgp_pkg::OP_DIVY_DONE: r_y <= quo_s24;
            default: ;
        endcase
    end

    // Frame bounds and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minx   <= pgp_pkg::S24_MAX;
            r_miny   <= pgp_pkg::S24_MAX;
            r_maxx   <= pgp_pkg::S24_MIN;
            r_maxy   <= pgp_pkg::S24_MIN;
            r_any    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.op == pgp_pkg::OP_EMIT_PT) begin
                if (r_wx < r_minx) r_minx <= r_wx;
                if (r_wx > r_maxx) r_maxx <= r_wx;
                if (r_wy < r_miny) r_miny <= r_wy;
                if (r_wy > r_maxy) r_maxy <= r_wy;
                r_any    <= 1'b1;
                r_ovalid <= 1'b1;
            end else if (i_cmd.op == pgp_pkg::OP_EMIT_BOX) begin
                r_minx   <= pgp_pkg::S24_MAX;
                r_miny   <= pgp_pkg::S24_MAX;
                r_maxx   <= pgp_pkg::S24_MIN;
                r_maxy   <= pgp_pkg::S24_MIN;
                r_any    <= 1'b0;
                r_ovalid <= 1'b1;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pgp_pkg::OP_EMIT_PT) begin
            r_okind  <= 1'b0;
            r_ofx    <= r_wx;
            r_ofy    <= r_wy;
            r_osx    <= 24'd0;
            r_osy    <= 24'd0;
            r_oempty <= 1'b0;
            r_olast  <= !r_last;
        end else if (i_cmd.op == pgp_pkg::OP_EMIT_BOX) begin
            r_okind  <= 1'b1;
            r_ofx    <= r_any ? r_minx : 24'd0;
            r_ofy    <= r_any ? r_miny : 24'd0;
            r_osx    <= r_any ? r_maxx : 24'd0;
            r_osy    <= r_any ? r_maxy : 24'd0;
            r_oempty <= !r_any;
            r_olast  <= 1'b1;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_kind         = r_okind;
    assign o_first_x      = r_ofx;
    assign o_first_y      = r_ofy;
    assign o_second_x     = r_osx;
    assign o_second_y     = r_osy;
    assign o_bounds_empty = r_oempty;
    assign o_last_result  = r_olast;

endmodule

`default_nettype wire

// File: hdl/pgp_ctrl.sv
// Controller: sequences the datapath operations for one request at a time.
`default_nettype none

module pgp_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  pgp_pkg::t_sts i_sts,
    output pgp_pkg::t_cmd o_cmd
);

    localparam logic [5:0] ST_IDLE      = 6'd0;
    localparam logic [5:0] ST_DECIDE    = 6'd1;
    localparam logic [5:0] ST_CINIT_P   = 6'd2;
    localparam logic [5:0] ST_CSTEP_P   = 6'd3;
    localparam logic [5:0] ST_CDONE_P   = 6'd4;
    localparam logic [5:0] ST_CINIT_H   = 6'd5;
    localparam logic [5:0] ST_CSTEP_H   = 6'd6;
    localparam logic [5:0] ST_CDONE_H   = 6'd7;
    localparam logic [5:0] ST_MUL_F2CP  = 6'd8;
    localparam logic [5:0] ST_MUL_D2SP  = 6'd9;
    localparam logic [5:0] ST_MUL_F2SP  = 6'd10;
    localparam logic [5:0] ST_MUL_D2CP  = 6'd11;
    localparam logic [5:0] ST_MUL_HCLO  = 6'd12;
    localparam logic [5:0] ST_MUL_HCHI  = 6'd13;
    localparam logic [5:0] ST_DIVR_SET  = 6'd14;
    localparam logic [5:0] ST_DIVR_STEP = 6'd15;
    localparam logic [5:0] ST_DIVR_DONE = 6'd16;
    localparam logic [5:0] ST_MUL_RCP   = 6'd17;
    localparam logic [5:0] ST_MUL_HCSP  = 6'd18;
    localparam logic [5:0] ST_RP        = 6'd19;
    localparam logic [5:0] ST_MUL_RPW2  = 6'd20;
    localparam logic [5:0] ST_DIVY_SET  = 6'd21;
    localparam logic [5:0] ST_DIVY_STEP = 6'd22;
    localparam logic [5:0] ST_DIVY_DONE = 6'd23;
    localparam logic [5:0] ST_MUL_XCH   = 6'd24;
    localparam logic [5:0] ST_MUL_YSH   = 6'd25;
    localparam logic [5:0] ST_MUL_XSH   = 6'd26;
    localparam logic [5:0] ST_MUL_YCH   = 6'd27;
    localparam logic [5:0] ST_WY        = 6'd28;
    localparam logic [5:0] ST_EMIT_PT   = 6'd29;
    localparam logic [5:0] ST_EMIT_BOX  = 6'd30;

    localparam logic [pgp_pkg::ITER_W-1:0] CORDIC_LAST =
        pgp_pkg::ITER_W'(pgp_pkg::CORDIC_STEPS - 1);
    localparam logic [pgp_pkg::ITER_W-1:0] DIV_LAST =
        pgp_pkg::ITER_W'(pgp_pkg::DIV_STEPS - 1);

    logic [5:0]                r_state, n_state;
    logic [pgp_pkg::ITER_W-1:0] r_iter, n_iter;
    logic [4:0]                op;

    assign o_in_ready = r_state == ST_IDLE;
    assign o_cmd.load = o_in_ready && i_in_valid;
    assign o_cmd.op   = op;
    assign o_cmd.iter = r_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // Next state and the operation issued in each state.
    always_comb begin
        n_state = r_state;
        n_iter  = '0;
        op      = pgp_pkg::OP_NOP;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_sts.mark)      n_state = ST_CINIT_P;
                else if (i_sts.last) n_state = ST_EMIT_BOX;
                else                 n_state = ST_IDLE;
            end
            ST_CINIT_P: begin op = pgp_pkg::OP_CINIT_P; n_state = ST_CSTEP_P; end
            ST_CSTEP_P: begin
                op     = pgp_pkg::OP_CSTEP;
                n_iter = r_iter + 1'b1;
                if (r_iter == CORDIC_LAST) begin
                    n_iter  = '0;
                    n_state = ST_CDONE_P;
                end
            end
            ST_CDONE_P: begin op = pgp_pkg::OP_CDONE_P; n_state = ST_CINIT_H; end
            ST_CINIT_H: begin op = pgp_pkg::OP_CINIT_H; n_state = ST_CSTEP_H; end
            ST_CSTEP_H: begin
                op     = pgp_pkg::OP_CSTEP;
                n_iter = r_iter + 1'b1;
                if (r_iter == CORDIC_LAST) begin
                    n_iter  = '0;
                    n_state = ST_CDONE_H;
                end
            end
            ST_CDONE_H:  begin op = pgp_pkg::OP_CDONE_H;  n_state = ST_MUL_F2CP; end
            ST_MUL_F2CP: begin op = pgp_pkg::OP_MUL_F2CP; n_state = ST_MUL_D2SP; end
            ST_MUL_D2SP: begin op = pgp_pkg::OP_MUL_D2SP; n_state = ST_MUL_F2SP; end
            ST_MUL_F2SP: begin op = pgp_pkg::OP_MUL_F2SP; n_state = ST_MUL_D2CP; end
            ST_MUL_D2CP: begin op = pgp_pkg::OP_MUL_D2CP; n_state = ST_MUL_HCLO; end
            ST_MUL_HCLO: begin op = pgp_pkg::OP_MUL_HCLO; n_state = ST_MUL_HCHI; end
            ST_MUL_HCHI: begin op = pgp_pkg::OP_MUL_HCHI; n_state = ST_DIVR_SET; end
            ST_DIVR_SET: begin op = pgp_pkg::OP_DIVR_SET; n_state = ST_DIVR_STEP; end
            ST_DIVR_STEP: begin
                op     = pgp_pkg::OP_DIV_STEP;
                n_iter = r_iter + 1'b1;
                if (r_iter == DIV_LAST) begin
                    n_iter  = '0;
                    n_state = ST_DIVR_DONE;
                end
            end
            ST_DIVR_DONE: begin op = pgp_pkg::OP_DIVR_DONE; n_state = ST_MUL_RCP; end
            ST_MUL_RCP:   begin op = pgp_pkg::OP_MUL_RCP;   n_state = ST_MUL_HCSP; end
            ST_MUL_HCSP:  begin op = pgp_pkg::OP_MUL_HCSP;  n_state = ST_RP; end
            ST_RP:        begin op = pgp_pkg::OP_RP;        n_state = ST_MUL_RPW2; end
            ST_MUL_RPW2:  begin op = pgp_pkg::OP_MUL_RPW2;  n_state = ST_DIVY_SET; end
            ST_DIVY_SET:  begin op = pgp_pkg::OP_DIVY_SET;  n_state = ST_DIVY_STEP; end
            ST_DIVY_STEP: begin
                op     = pgp_pkg::OP_DIV_STEP;
                n_iter = r_iter + 1'b1;
                if (r_iter == DIV_LAST) begin
                    n_iter  = '0;
                    n_state = ST_DIVY_DONE;
                end
            end
            ST_DIVY_DONE: begin op = pgp_pkg::OP_DIVY_DONE; n_state = ST_MUL_XCH; end
            ST_MUL_XCH:   begin op = pgp_pkg::OP_MUL_XCH;   n_state = ST_MUL_YSH; end
            ST_MUL_YSH:   begin op = pgp_pkg::OP_MUL_YSH;   n_state = ST_MUL_XSH; end
            ST_MUL_XSH:   begin op = pgp_pkg::OP_MUL_XSH;   n_state = ST_MUL_YCH; end
            ST_MUL_YCH:   begin op = pgp_pkg::OP_MUL_YCH;   n_state = ST_WY; end
            ST_WY:        begin op = pgp_pkg::OP_WY;        n_state = ST_EMIT_PT; end
            // Results wait here until the result register is free.
            ST_EMIT_PT: begin
                if (!i_sts.out_full) begin
                    op      = pgp_pkg::OP_EMIT_PT;
                    n_state = i_sts.last ? ST_EMIT_BOX : ST_IDLE;
                end
            end
            ST_EMIT_BOX: begin
                if (!i_sts.out_full) begin
                    op      = pgp_pkg::OP_EMIT_BOX;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/pixel_ground_projection_top.sv
// Top level of the pixel ground projection block.
//
// Mask pixels enter on the slave stream: tdata holds row and column, tuser the
// path flag (zero marks an obstacle pixel) and tlast the last pixel of a frame.
// Each marked pixel inside the frame yields one world point on the master
// stream; the last pixel of a frame also yields the frame bounding box after
// that point, with tlast set on the final result of the request.
// A marked pixel's point is computed with two 17-step CORDIC passes for the
// pitch and heading sine and cosine, and two 62-step restoring divisions for
// the ground distance and the lateral offset, on one shared multiplier and
// one shared divider. One request is processed at a time; tready is high
// only between requests. Results leave through a one-entry result register,
// so the next request is taken while a result is still waiting; when the
// receiver stalls, the controller holds before writing the next result.
// Configuration is written through the APB port between frames; the user
// must keep to this, as the block does not enforce it. Reset is synchronous
// and restores the default registers and empties the bounds.
`default_nettype none

module pixel_ground_projection_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [23:0]   i_s_axis_tdata,   // row [11:0], col [23:12]
    input  wire logic          i_s_axis_tuser,   // path_flag
    input  wire logic          i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic      [95:0]   o_m_axis_tdata,   // first_x, first_y, second_x, second_y
    output logic      [1:0]    o_m_axis_tuser,   // kind [0], bounds_empty [1]
    output logic               o_m_axis_tlast,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);

    pgp_pkg::t_cfg cfg;
    pgp_pkg::t_cmd cmd;
    pgp_pkg::t_sts sts;

    logic        kind, empty;
    logic [23:0] fx, fy, sx, sy;

    pgp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pgp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_row          (i_s_axis_tdata[11:0]),
        .i_col          (i_s_axis_tdata[23:12]),
        .i_flag         (i_s_axis_tuser),
        .i_last         (i_s_axis_tlast),
        .i_out_tready   (i_m_axis_tready),
        .o_sts          (sts),
        .o_out_valid    (o_m_axis_tvalid),
        .o_kind         (kind),
        .o_first_x      (fx),
        .o_first_y      (fy),
        .o_second_x     (sx),
        .o_second_y     (sy),
        .o_bounds_empty (empty),
        .o_last_result  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {sy, sx, fy, fx};
    assign o_m_axis_tuser = {empty, kind};

    // A request is taken only while the controller is idle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request accepted while a request was in progress");

    // Points carry no second corner and never flag an empty frame.
    a_point_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata[95:48] == 48'd0 && !o_m_axis_tuser[1])
        else $error("point result with box fields set");

    // An empty frame box has all coordinates zero and closes the request.
    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] && o_m_axis_tuser[1] |->
            o_m_axis_tdata == 96'd0 && o_m_axis_tlast)
        else $error("empty frame box with nonzero coordinates");

    // A filled box has its minimum corner at or below its maximum corner.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] && !o_m_axis_tuser[1] |->
            $signed(o_m_axis_tdata[23:0]) <= $signed(o_m_axis_tdata[71:48]) &&
            $signed(o_m_axis_tdata[47:24]) <= $signed(o_m_axis_tdata[95:72]))
        else $error("bounding box corners out of order");

endmodule

`default_nettype wire

// File: test/pixel_ground_projection_top_tb.sv
// Self-checking testbench for the pixel ground projection block: stream stimulus, APB setup, predictor.
`default_nettype none

module pixel_ground_projection_top_tb;

    typedef struct {
        bit     kind;
        longint fx;
        longint fy;
        longint sx;
        longint sy;
        bit     empty;
        bit     last;
    } t_result;

    typedef struct {
        int unsigned row;
        int unsigned col;
        bit          flag;
        bit          last;
        bit          empty_box;   // expected result is a lone empty box, typed in
    } t_pixel_row;

    localparam longint ATAN_TAB [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2, 1};
    localparam longint CORDIC_START = 652032874;
    localparam int     SETTLE       = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         s_ready;
    wire         m_valid;
    wire  [95:0] m_data;      // first_x, first_y, second_x, second_y
    wire  [1:0]  m_user;      // kind [0], bounds_empty [1]
    wire         m_last;
    wire  [31:0] prdata;
    wire         pready;

    // Predictor copy of the registers and the frame bounds.
    longint cfg_width, cfg_height, cfg_cam_h, cfg_pitch, cfg_focal;
    longint cfg_rx, cfg_ry, cfg_heading;
    longint box_min_x, box_min_y, box_max_x, box_max_y;
    bit     box_valid;

    t_result expected_results[$];
    int      mismatches = 0;
    int      burst_left = 0;

    pixel_ground_projection_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint clamp24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic bit same_result(input t_result a, input t_result b);
        return a.kind == b.kind && a.fx == b.fx && a.fy == b.fy && a.sx == b.sx &&
               a.sy == b.sy && a.empty == b.empty && a.last == b.last;
    endfunction

    // CORDIC sine and cosine in Q30, angle folded into the half-pi range first.
    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     neg;
        z = ang;
        x = CORDIC_START;
        y = 0;
        neg = 1'b0;
        while (z > longint'(pgp_pkg::ANG_HALF_PI)) begin
            z -= longint'(pgp_pkg::ANG_PI);
            neg = ~neg;
        end
        while (z < -longint'(pgp_pkg::ANG_HALF_PI)) begin
            z += longint'(pgp_pkg::ANG_PI);
            neg = ~neg;
        end
        for (int i = 0; i < 17; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x -= dy; y += dx; z -= ATAN_TAB[i];
            end else begin
                x += dy; y -= dx; z += ATAN_TAB[i];
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    // Ground point of one pixel, rotated and offset into the world frame.
    task automatic world_point(input longint row, input longint col,
                               output longint wx, output longint wy);
        longint sp, cp, sh, ch, num, den, prod, r, x, y, rp, f2, d2, w2;
        f2 = 2 * ((cfg_focal != 0) ? cfg_focal : 1);
        d2 = 2 * row - cfg_height;
        w2 = 2 * col - cfg_width;
        cordic_sincos(cfg_pitch, sp, cp);
        num = f2 * cp - d2 * sp;
        den = f2 * sp + d2 * cp;
        prod = cfg_cam_h * num;
        if (den == 0) begin
            r = (prod > 0) ? 8388607 : ((prod < 0) ? -8388608 : 0);
        end else begin
            r = clamp24(prod / den);
        end
        x = clamp24(pgp_pkg::CAM_OFFSET_X_MM + r);
        rp = round_q30(r * cp + cfg_cam_h * sp);
        y = clamp24(-(rp * w2) / f2);
        cordic_sincos(cfg_heading, sh, ch);
        wx = clamp24(cfg_rx + round_q30(x * ch - y * sh));
        wy = clamp24(cfg_ry + round_q30(x * sh + y * ch));
    endtask

    function automatic void clear_box();
        box_min_x = 8388607;
        box_min_y = 8388607;
        box_max_x = -8388608;
        box_max_y = -8388608;
        box_valid = 1'b0;
    endfunction

    // Expected results of one accepted pixel request.
    task automatic predict_pixel(input t_pixel_row p, output t_result res[$]);
        t_result t;
        longint  wx, wy;
        res = {};
        if (!p.flag && p.row >= pgp_pkg::START_ROW && p.row < cfg_height &&
            p.col < cfg_width) begin
            world_point(p.row, p.col, wx, wy);
            if (wx < box_min_x) box_min_x = wx;
            if (wx > box_max_x) box_max_x = wx;
            if (wy < box_min_y) box_min_y = wy;
            if (wy > box_max_y) box_max_y = wy;
            box_valid = 1'b1;
            t = '{0, wx, wy, 0, 0, 0, 0};
            res = {res, t};
        end
        if (p.last) begin
            if (box_valid) t = '{1, box_min_x, box_min_y, box_max_x, box_max_y, 0, 0};
            else           t = '{1, 0, 0, 0, 0, 1, 0};
            res = {res, t};
            clear_box();
        end
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    endtask

    // APB write: setup cycle, then access cycle; predictor follows at the write edge.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            pgp_pkg::REG_FRAME_WIDTH:   cfg_width = value[12:0];
            pgp_pkg::REG_FRAME_HEIGHT:  cfg_height = value[12:0];
            pgp_pkg::REG_CAM_HEIGHT:    cfg_cam_h = value[11:0];
            pgp_pkg::REG_CAM_PITCH:     cfg_pitch = value[16:0];
            pgp_pkg::REG_FOCAL_LENGTH:  cfg_focal = value[15:0];
            pgp_pkg::REG_ROBOT_X:       cfg_rx = longint'(signed'(value[23:0]));
            pgp_pkg::REG_ROBOT_Y:       cfg_ry = longint'(signed'(value[23:0]));
            pgp_pkg::REG_ROBOT_HEADING: cfg_heading = longint'(signed'(value[18:0]));
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Send one pixel request in bursts; returns at the falling edge after acceptance.
    task automatic send_pixel(input t_pixel_row p);
        t_result res[$];
        t_result lone_box;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_valid = 1'b1;
        s_data = {p.col[11:0], p.row[11:0]};
        s_user = p.flag;
        s_last = p.last;
        do @(posedge i_clk); while (!s_ready);
        predict_pixel(p, res);
        if (p.empty_box) begin
            lone_box = '{1, 0, 0, 0, 0, 1, 1};
            expected_results = {expected_results, lone_box};
        end else begin
            expected_results = {expected_results, res};
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        wait (expected_results.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Receiver stall pattern, renewed now and then; sometimes always ready.
    initial begin
        logic [15:0] pattern;
        int          pos;
        pattern = 16'hFFFF;
        pos = 0;
        forever begin
            @(negedge i_clk);
            if (pos % 97 == 0) begin
                pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
            end
            m_ready <= pattern[pos % 16];
            pos++;
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_valid && m_ready) begin
            got = '{m_user[0], longint'(signed'(m_data[23:0])), longint'(signed'(m_data[47:24])),
                    longint'(signed'(m_data[71:48])), longint'(signed'(m_data[95:72])),
                    m_user[1], m_last};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result kind=%0d x=%0d y=%0d",
                                               got.kind, got.fx, got.fy);
            end else begin
                want = expected_results.pop_front();
                if (!same_result(got, want)) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected k=%0d %0d %0d %0d %0d e=%0d l=%0d",
                                 want.kind, want.fx, want.fy, want.sx, want.sy,
                                 want.empty, want.last);
                        $display("          actual   k=%0d %0d %0d %0d %0d e=%0d l=%0d",
                                 got.kind, got.fx, got.fy, got.sx, got.sy,
                                 got.empty, got.last);
                    end
                end
            end
        end
    end

    initial begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

    // Directed table under the reset setup (640 x 480).
    t_pixel_row directed [15] = '{
        '{0,    0,    0, 0, 0},
        '{479,  639,  0, 0, 0},
        '{240,  320,  0, 0, 0},
        '{239,  0,    0, 0, 0},
        '{0,    639,  0, 0, 0},
        '{4095, 4095, 0, 1, 0},   // outside the frame, closes a marked frame
        '{100,  100,  1, 1, 1},   // unmarked pixel only: empty box
        '{480,  10,   0, 1, 1},   // row just outside the frame
        '{10,   640,  0, 1, 1},   // column just outside the frame
        '{4095, 0,    0, 0, 0},
        '{0,    4095, 1, 0, 0},
        '{2730, 2730, 1, 0, 0},
        '{1365, 1365, 1, 1, 1},
        '{479,  0,    0, 1, 0},   // point and box from one request
        '{0,    0,    1, 1, 1}
    };

    initial begin
        t_pixel_row p;
        int         frame_left;
        logic [31:0] v;
        cfg_width = 640; cfg_height = 480; cfg_cam_h = 500; cfg_pitch = 16384;
        cfg_focal = 500; cfg_rx = 0; cfg_ry = 0; cfg_heading = 0;
        clear_box();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) send_pixel(directed[k]);
        wait_idle();

        // Random phases, each under a new setup, extremes in the first two.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin
                    reg_write(pgp_pkg::REG_FRAME_WIDTH, 4096);
                    reg_write(pgp_pkg::REG_FRAME_HEIGHT, 4096);
                    reg_write(pgp_pkg::REG_CAM_HEIGHT, 4095);
                    reg_write(pgp_pkg::REG_CAM_PITCH, 102943);
                    reg_write(pgp_pkg::REG_FOCAL_LENGTH, 65535);
                    reg_write(pgp_pkg::REG_ROBOT_X, 32'h007FFFFF);
                    reg_write(pgp_pkg::REG_ROBOT_Y, 32'hFF800000);
                    reg_write(pgp_pkg::REG_ROBOT_HEADING, 32'h0003243F);
                end
                1: begin
                    reg_write(pgp_pkg::REG_FRAME_WIDTH, 1);
                    reg_write(pgp_pkg::REG_FRAME_HEIGHT, 1);
                    reg_write(pgp_pkg::REG_CAM_HEIGHT, 0);
                    reg_write(pgp_pkg::REG_CAM_PITCH, 0);
                    reg_write(pgp_pkg::REG_FOCAL_LENGTH, 0);
                    reg_write(pgp_pkg::REG_ROBOT_X, 32'hFF800000);
                    reg_write(pgp_pkg::REG_ROBOT_Y, 32'h007FFFFF);
                    reg_write(pgp_pkg::REG_ROBOT_HEADING, 32'hFFFCDBC1);
                end
                default: begin
                    v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8191)
                                                    : $urandom_range(1, 96);
                    reg_write(pgp_pkg::REG_FRAME_WIDTH, v);
                    v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8191)
                                                    : $urandom_range(1, 96);
                    reg_write(pgp_pkg::REG_FRAME_HEIGHT, v);
                    reg_write(pgp_pkg::REG_CAM_HEIGHT, $urandom);
                    v = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 102943);
                    reg_write(pgp_pkg::REG_CAM_PITCH, v);
                    reg_write(pgp_pkg::REG_FOCAL_LENGTH, $urandom);
                    reg_write(pgp_pkg::REG_ROBOT_X, $urandom);
                    reg_write(pgp_pkg::REG_ROBOT_Y, $urandom);
                    reg_write(pgp_pkg::REG_ROBOT_HEADING, $urandom);
                end
            endcase

            // Well-formed frames of random length, with some stray coordinates.
            frame_left = 0;
            for (int n = 0; n < 170; n++) begin
                if (frame_left == 0) frame_left = $urandom_range(1, 30);
                frame_left--;
                p.row = ($urandom_range(0, 7) == 0 || cfg_height == 0)
                        ? $urandom_range(0, 4095)
                        : $urandom_range(0, (cfg_height > 4096 ? 4096 : cfg_height) - 1);
                p.col = ($urandom_range(0, 7) == 0 || cfg_width == 0)
                        ? $urandom_range(0, 4095)
                        : $urandom_range(0, (cfg_width > 4096 ? 4096 : cfg_width) - 1);
                p.flag = ($urandom_range(0, 3) == 0);
                p.last = (frame_left == 0) || (n == 169);
                p.empty_box = 1'b0;
                send_pixel(p);
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/pgp_pkg.sv
hdl/pgp_regs.sv
hdl/pgp_dp.sv
hdl/pgp_ctrl.sv
hdl/pixel_ground_projection_top.sv
test/pixel_ground_projection_top_tb.sv
